// ===== src/gyro_heading_integrator_assert.svh =====
// Assertion macros shared by the checker files of the heading integrator.
// Each macro expands to one labelled concurrent assertion that is clocked on
// the rising edge and switched off while reset is held.
`ifndef GYRO_HEADING_INTEGRATOR_ASSERT_SVH
`define GYRO_HEADING_INTEGRATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHI_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GHI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ghi_pkg.sv =====
package ghi_pkg;

    localparam int RATE_W     = 16;
    localparam int TIME_W     = 32;
    localparam int HEAD_W     = 32;
    localparam int FS_W       = 11;
    localparam int INT_W      = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int CAL_SAMPLES_DEF = 32;
    localparam int US_PER_S        = 1000000;
    // Converting raw/32768 deg/s into Q9.23 degrees is a left shift by 8.
    localparam int RND_SHIFT       = 8;

    // 360 degrees in Q9.23.
    localparam logic [HEAD_W-1:0] HEAD_MOD = 32'd3019898880;

    localparam logic [FS_W-1:0]  FULL_SCALE_RST = 11'd1000;
    localparam logic [INT_W-1:0] DRIFT_INT_RST  = 16'd100;

    // Width of |raw * CAL_SAMPLES - bias_sum|.
    function automatic int ghi_mag_w(input int cal);
        return RATE_W + $clog2(cal + 1);
    endfunction

    // Width of |diff| * full_scale * dt.
    function automatic int ghi_prod_w(input int cal);
        return ghi_mag_w(cal) + FS_W + TIME_W;
    endfunction

    // Quotient bits produced by the serial divider.
    function automatic int ghi_div_steps(input int cal);
        return ghi_prod_w(cal) + RND_SHIFT;
    endfunction

    typedef struct packed {
        logic cal_acc;
        logic load;
        logic scale;
        logic mul_step;
        logic div_step;
        logic round;
        logic apply;
        logic drift_add;
        logic snap;
        logic drift_calc;
    } t_axis_ctrl;

endpackage

// ===== src/ghi_axis.sv =====
module ghi_axis #(
    parameter int CAL_SAMPLES = ghi_pkg::CAL_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ghi_pkg::t_axis_ctrl               i_ctrl,
    input  logic signed [ghi_pkg::RATE_W-1:0] i_rate,
    input  logic [ghi_pkg::FS_W-1:0]          i_full_scale,
    input  logic [ghi_pkg::TIME_W-1:0]        i_dt,
    output logic [ghi_pkg::HEAD_W-1:0]        o_heading
);
    import ghi_pkg::*;

    localparam int MAG_W   = ghi_mag_w(CAL_SAMPLES);
    localparam int DIFF_W  = MAG_W + 1;
    localparam int MUL_W   = MAG_W + FS_W;
    localparam int PROD_W  = ghi_prod_w(CAL_SAMPLES);
    localparam int DIVISOR = US_PER_S * CAL_SAMPLES;
    localparam int DIV_W   = $clog2(DIVISOR + 1);
    localparam int REM_W   = DIV_W + 1;

    localparam logic signed [DIFF_W-1:0] CAL_S     = DIFF_W'(CAL_SAMPLES);
    localparam logic [REM_W-1:0]         DIVISOR_R = REM_W'(DIVISOR);
    localparam logic [HEAD_W:0]          MOD_X     = {1'b0, HEAD_MOD};

    function automatic logic [HEAD_W-1:0] mod_add(input logic [HEAD_W-1:0] a,
                                                  input logic [HEAD_W-1:0] b);
        logic [HEAD_W:0] s;
        logic [HEAD_W:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - MOD_X;
        return (s >= MOD_X) ? t[HEAD_W-1:0] : s[HEAD_W-1:0];
    endfunction

    function automatic logic [HEAD_W-1:0] mod_sub(input logic [HEAD_W-1:0] a,
                                                  input logic [HEAD_W-1:0] b);
        logic [HEAD_W:0] d;
        logic [HEAD_W:0] t;
        d = {1'b0, a} - {1'b0, b};
        t = d + MOD_X;
        return (a >= b) ? d[HEAD_W-1:0] : t[HEAD_W-1:0];
    endfunction

    logic signed [DIFF_W-1:0] r_bias_sum;
    logic                     r_pos;
    logic [MAG_W-1:0]         r_mag;
    logic [MUL_W-1:0]         r_mult;
    logic [PROD_W-1:0]        r_prod;
    logic [DIV_W-1:0]         r_rem;
    logic [HEAD_W-1:0]        r_qm;
    logic [HEAD_W-1:0]        r_heading;
    logic [HEAD_W-1:0]        r_drift;
    logic [HEAD_W-1:0]        r_snap;

    logic signed [DIFF_W-1:0] w_rate_ext;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_neg_diff;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_pos;
    logic [MUL_W:0]           w_mul_sum;
    logic [REM_W-1:0]         w_cur;
    logic [REM_W-1:0]         w_cur_sub;
    logic                     w_ge;
    logic [HEAD_W:0]          w_q2;
    logic [HEAD_W:0]          w_q2_sub;
    logic [HEAD_W-1:0]        w_qm_shift;
    logic                     w_half;

    // Signed difference between the scaled sample and the bias sum.
    assign w_rate_ext = DIFF_W'(i_rate);
    assign w_diff     = w_rate_ext * CAL_S - r_bias_sum;
    assign w_neg_diff = -w_diff;
    assign w_mag      = w_diff[DIFF_W-1] ? w_neg_diff[MAG_W-1:0] : w_diff[MAG_W-1:0];
    assign w_pos      = !w_diff[DIFF_W-1] && (w_diff != '0);

    // Shift-add multiplier: one bit of dt per cycle, LSB first.
    assign w_mul_sum = {1'b0, r_prod[PROD_W-1:TIME_W]} + (r_prod[0] ? {1'b0, r_mult} : '0);

    // Restoring divider: one quotient bit per cycle, MSB first. The quotient is
    // kept reduced modulo a full turn as it is built.
    assign w_cur      = {r_rem, r_prod[PROD_W-1]};
    assign w_ge       = (w_cur >= DIVISOR_R);
    assign w_cur_sub  = w_cur - DIVISOR_R;
    assign w_q2       = {r_qm, w_ge};
    assign w_q2_sub   = w_q2 - MOD_X;
    assign w_qm_shift = (w_q2 >= MOD_X) ? w_q2_sub[HEAD_W-1:0] : w_q2[HEAD_W-1:0];
    assign w_half     = ({r_rem, 1'b0} >= DIVISOR_R);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_sum <= '0;
            r_heading  <= '0;
            r_drift    <= '0;
            r_snap     <= '0;
        end else begin
            if (i_ctrl.cal_acc) begin
                r_bias_sum <= r_bias_sum + w_rate_ext;
            end
            if (i_ctrl.apply) begin
                r_heading <= r_pos ? mod_sub(r_heading, r_qm) : mod_add(r_heading, r_qm);
            end else if (i_ctrl.drift_add) begin
                r_heading <= mod_add(r_heading, r_drift);
            end
            if (i_ctrl.snap) begin
                r_snap <= r_heading;
            end
            if (i_ctrl.drift_calc) begin
                r_drift <= mod_sub(r_heading, r_snap);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_pos <= w_pos;
            r_mag <= w_mag;
        end
        if (i_ctrl.scale) begin
            r_mult <= MUL_W'(r_mag) * MUL_W'(i_full_scale);
            r_prod <= PROD_W'(i_dt);
            r_rem  <= '0;
            r_qm   <= '0;
        end else if (i_ctrl.mul_step) begin
            r_prod <= {w_mul_sum, r_prod[TIME_W-1:1]};
        end else if (i_ctrl.div_step) begin
            r_prod <= {r_prod[PROD_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_cur_sub[DIV_W-1:0] : w_cur[DIV_W-1:0];
            r_qm   <= w_qm_shift;
        end else if (i_ctrl.round) begin
            if (w_half) begin
                r_qm <= mod_add(r_qm, HEAD_W'(1));
            end
        end
    end

    assign o_heading = r_heading;

endmodule

// ===== src/gyro_heading_integrator.sv =====
// Gyro heading integrator. Each input transaction carries one gyro sample (raw
// Y and Z rate registers and free-running microsecond and millisecond
// timestamps) and produces exactly one output transaction with the horizontal
// heading (from Z), the vertical heading (from the negated Y rate) and a
// ready_res flag; headings are unsigned Q9.23 degrees in [0,360). The first
// CAL_SAMPLES transactions only accumulate the rate biases and return zero
// headings; the next two run normal updates and measure a per-axis drift, and
// ready_res rises on the second of them. Each update multiplies the
// bias-corrected rate by full_scale_dps and by the elapsed microseconds in a
// bit-serial shift-add multiplier and then divides by 1e6 * CAL_SAMPLES in a
// restoring divider that produces one quotient bit per cycle (mag + 11 + 32
// + 8 bits, 73 bits at CAL_SAMPLES = 32). One sample is processed at a time; a
// new sample is accepted as soon as the previous result sits in the output
// register, even while that result is still stalled. Configuration goes
// through an APB-style port: full_scale_dps at address 0 and drift_interval_ms
// at address 4, both to be written only while the block is idle; the block
// itself does not enforce this.
module gyro_heading_integrator #(
    parameter int CAL_SAMPLES = ghi_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ghi_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [ghi_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [ghi_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    // Sample input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [ghi_pkg::RATE_W-1:0]     i_rate_y_raw,
    input  logic signed [ghi_pkg::RATE_W-1:0]     i_rate_z_raw,
    input  logic [ghi_pkg::TIME_W-1:0]            i_time_us,
    input  logic [ghi_pkg::TIME_W-1:0]            i_time_ms,
    // Heading output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ghi_pkg::HEAD_W-1:0]            o_horizontal_heading,
    output logic [ghi_pkg::HEAD_W-1:0]            o_vertical_heading,
    output logic                                  o_ready_res
);
    import ghi_pkg::*;

    localparam int MUL_STEPS = TIME_W;
    localparam int DIV_STEPS = ghi_div_steps(CAL_SAMPLES);
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);

    localparam logic REG_FULL_SCALE = 1'b0;
    localparam logic REG_DRIFT_INT  = 1'b1;

    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};

    typedef enum logic [10:0] {
        ST_IDLE   = 11'd1,
        ST_CAL    = 11'd2,
        ST_LOAD   = 11'd4,
        ST_SCALE  = 11'd8,
        ST_MUL    = 11'd16,
        ST_DIV    = 11'd32,
        ST_ROUND  = 11'd64,
        ST_APPLY  = 11'd128,
        ST_DRIFT  = 11'd256,
        ST_FINISH = 11'd512,
        ST_OUT    = 11'd1024
    } t_state;

    // Operating phase: bias calibration, first update, second update (which
    // fixes the drift), then normal running.
    typedef enum logic [3:0] {
        PH_CAL    = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_SECOND = 4'b0100,
        PH_RUN    = 4'b1000
    } t_phase;

    t_state                    r_state;
    t_state                    n_state;
    t_phase                    r_phase;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [STEP_W-1:0]         r_step;
    logic [FS_W-1:0]           r_full_scale;
    logic [INT_W-1:0]          r_drift_int;
    logic [TIME_W-1:0]         r_prev_us;
    logic [TIME_W-1:0]         r_last_ms;
    logic                      r_out_valid;

    logic signed [RATE_W-1:0]  r_rate_y;
    logic signed [RATE_W-1:0]  r_rate_z;
    logic [TIME_W-1:0]         r_time_us;
    logic [TIME_W-1:0]         r_time_ms;
    logic [TIME_W-1:0]         r_dt;
    logic                      r_drift_due;
    logic [HEAD_W-1:0]         r_out_h;
    logic [HEAD_W-1:0]         r_out_v;
    logic                      r_out_ready;

    logic signed [RATE_W-1:0]  w_rate_y;
    logic [TIME_W-1:0]         w_ms_gap;
    logic                      w_in_take;
    logic                      w_out_load;
    logic                      w_cfg_write;
    t_axis_ctrl                w_ctrl;
    logic [HEAD_W-1:0]         w_head_h;
    logic [HEAD_W-1:0]         w_head_v;

    // ------------------------------------------------------------------
    // Configuration port. Only paddr[2] selects a register (reads return zero
    // unless paddr[1:0] is zero); the port never waits.
    // ------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_FULL_SCALE: prdata = APB_DATA_W'(r_full_scale);
                REG_DRIFT_INT:  prdata = APB_DATA_W'(r_drift_int);
                default:        prdata = '0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes. A sample is taken only in IDLE; the result waits in the
    // output register so the next sample can enter while it is stalled.
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_take  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    // The Y rate is negated; the most negative code has no positive twin and
    // saturates to the largest positive one.
    assign w_rate_y = (i_rate_y_raw == RATE_MIN) ? RATE_MAX : -i_rate_y_raw;

    assign n_count  = r_count + CNT_W'(1);
    assign w_ms_gap = r_time_ms - r_last_ms;

    // ------------------------------------------------------------------
    // Sequencer: next state and the control word for both axis datapaths.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        w_ctrl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (r_phase == PH_CAL) ? ST_CAL : ST_LOAD;
                end
            end
            ST_CAL: begin
                w_ctrl.cal_acc = 1'b1;
                n_state        = ST_OUT;
            end
            ST_LOAD: begin
                w_ctrl.load = 1'b1;
                n_state     = ST_SCALE;
            end
            ST_SCALE: begin
                w_ctrl.scale = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                w_ctrl.mul_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                w_ctrl.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                w_ctrl.round = 1'b1;
                n_state      = ST_APPLY;
            end
            ST_APPLY: begin
                w_ctrl.apply = 1'b1;
                n_state      = ST_DRIFT;
            end
            ST_DRIFT: begin
                w_ctrl.drift_add = r_drift_due;
                n_state          = ST_FINISH;
            end
            ST_FINISH: begin
                w_ctrl.snap       = (r_phase == PH_FIRST);
                w_ctrl.drift_calc = (r_phase == PH_SECOND);
                n_state           = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, timestamps that belong to the integration state, and the
    // configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_CAL;
            r_count      <= '0;
            r_step       <= '0;
            r_full_scale <= FULL_SCALE_RST;
            r_drift_int  <= DRIFT_INT_RST;
            r_prev_us    <= '0;
            r_last_ms    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_write) begin
                unique case (paddr[2])
                    REG_FULL_SCALE: r_full_scale <= pwdata[FS_W-1:0];
                    REG_DRIFT_INT:  r_drift_int  <= pwdata[INT_W-1:0];
                    default:        r_full_scale <= r_full_scale;
                endcase
            end

            // Calibration: the first sample also fixes the time base.
            if (r_state == ST_CAL) begin
                if (r_count == '0) begin
                    r_prev_us <= r_time_us;
                end
                r_count <= n_count;
                if (n_count >= CNT_W'(CAL_SAMPLES)) begin
                    r_phase <= PH_FIRST;
                end
            end

            if (r_state == ST_LOAD) begin
                r_prev_us <= r_time_us;
            end

            if (r_state == ST_SCALE) begin
                r_step <= STEP_W'(MUL_STEPS - 1);
            end else if (r_state == ST_MUL) begin
                r_step <= (r_step == '0) ? STEP_W'(DIV_STEPS - 1) : r_step - STEP_W'(1);
            end else if (r_state == ST_DIV) begin
                r_step <= r_step - STEP_W'(1);
            end

            if ((r_state == ST_DRIFT) && r_drift_due) begin
                r_last_ms <= r_time_ms;
            end

            // The second update ends the drift measurement; the drift timer
            // restarts from its sample whether or not a drift was added.
            if (r_state == ST_FINISH) begin
                if (r_phase == PH_FIRST) begin
                    r_phase <= PH_SECOND;
                end else if (r_phase == PH_SECOND) begin
                    r_phase   <= PH_RUN;
                    r_last_ms <= r_time_ms;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample latches, per-update operands and the output register.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_rate_y  <= w_rate_y;
            r_rate_z  <= i_rate_z_raw;
            r_time_us <= i_time_us;
            r_time_ms <= i_time_ms;
        end
        if (r_state == ST_LOAD) begin
            r_dt        <= r_time_us - r_prev_us;
            r_drift_due <= (w_ms_gap > TIME_W'(r_drift_int));
        end
        if (w_out_load) begin
            r_out_h     <= w_head_h;
            r_out_v     <= w_head_v;
            r_out_ready <= (r_phase == PH_RUN);
        end
    end

    // ------------------------------------------------------------------
    // Two identical axis datapaths run in lockstep under one control word.
    // ------------------------------------------------------------------
    ghi_axis #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_axis_h (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_rate       (r_rate_z),
        .i_full_scale (r_full_scale),
        .i_dt         (r_dt),
        .o_heading    (w_head_h)
    );

    ghi_axis #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_axis_v (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_rate       (r_rate_y),
        .i_full_scale (r_full_scale),
        .i_dt         (r_dt),
        .o_heading    (w_head_v)
    );

    assign o_out_valid          = r_out_valid;
    assign o_horizontal_heading = r_out_h;
    assign o_vertical_heading   = r_out_v;
    assign o_ready_res          = r_out_ready;

endmodule

// ===== src/ghi_check.sv =====
`include "gyro_heading_integrator_assert.svh"

module ghi_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [ghi_pkg::HEAD_W-1:0]   o_horizontal_heading,
    input logic [ghi_pkg::HEAD_W-1:0]   o_vertical_heading,
    input logic                         o_ready_res
);
    import ghi_pkg::*;

    // Set once a transaction with ready_res has left the block.
    logic r_ready_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_seen <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_ready_res) begin
            r_ready_seen <= 1'b1;
        end
    end

    // Both headings stay inside one full turn.
    `GHI_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, o_out_valid, (o_horizontal_heading < HEAD_MOD) && (o_vertical_heading < HEAD_MOD), "heading outside one full turn")

    // Once calibration and drift measurement are done they stay done.
    `GHI_ASSERT_NOW(a_ready_sticky, i_clk, i_rst_n, o_out_valid && r_ready_seen, o_ready_res, "ready_res dropped after it was reported")

    // Samples are processed one at a time.
    `GHI_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after a sample was taken")

    // A stalled result holds.
    `GHI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_horizontal_heading) && $stable(o_vertical_heading) && $stable(o_ready_res), "stalled result changed")

endmodule

bind gyro_heading_integrator ghi_check u_ghi_check (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_horizontal_heading (o_horizontal_heading),
    .o_vertical_heading   (o_vertical_heading),
    .o_ready_res          (o_ready_res)
);

// ===== tb/tb_gyro_heading_integrator.sv =====
// Testbench for the gyro heading integrator.
//
// Samples are queued by the stimulus process and handed to the block by a
// clocked driver; every accepted input transaction is run through a local
// predictor of the block, and its expected headings are queued. A clocked
// monitor compares each accepted output transaction against the oldest
// expected entry, field by field. Configuration registers are rewritten
// between phases, only once the block has drained completely.
module tb_gyro_heading_integrator;

    import ghi_pkg::*;

    localparam int CAL           = CAL_SAMPLES_DEF;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1500000;

    localparam logic [APB_ADDR_W-1:0] ADDR_FULL_SCALE = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_DRIFT_INT  = 3'd4;

    typedef enum logic [1:0] {
        STAGE_CALIBRATE,
        STAGE_FIRST_UPDATE,
        STAGE_SECOND_UPDATE,
        STAGE_RUNNING
    } t_stage;

    typedef struct packed {
        logic [RATE_W-1:0] rate_y;
        logic [RATE_W-1:0] rate_z;
        logic [TIME_W-1:0] t_us;
        logic [TIME_W-1:0] t_ms;
    } t_sample;

    typedef struct packed {
        logic [HEAD_W-1:0] horiz;
        logic [HEAD_W-1:0] vert;
        logic              ready;
    } t_headings;

    // Clock, reset and every block input start at a known value.
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [RATE_W-1:0] i_rate_y_raw = '0;
    logic [RATE_W-1:0] i_rate_z_raw = '0;
    logic [TIME_W-1:0] i_time_us    = '0;
    logic [TIME_W-1:0] i_time_ms    = '0;

    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [HEAD_W-1:0] o_horizontal_heading;
    logic [HEAD_W-1:0] o_vertical_heading;
    logic              o_ready_res;

    gyro_heading_integrator uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_rate_y_raw         (i_rate_y_raw),
        .i_rate_z_raw         (i_rate_z_raw),
        .i_time_us            (i_time_us),
        .i_time_ms            (i_time_ms),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_horizontal_heading (o_horizontal_heading),
        .o_vertical_heading   (o_vertical_heading),
        .o_ready_res          (o_ready_res)
    );

    // Pending samples, and the headings expected for accepted samples.
    t_sample   sample_queue[$];
    t_headings heading_queue[$];

    // Knobs set by the stimulus process for each phase.
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    bit pressure_on    = 1'b0;
    int hold_count     = 0;

    // Bookkeeping.
    int items_total       = 0;
    int samples_sent      = 0;
    int results_checked   = 0;
    int fail_count        = 0;
    int settings_count    = 0;
    int in_blocked_cycles = 0;
    int cycle_count       = 0;

    // Predictor copy of the configuration and of the integrator state.
    logic [FS_W-1:0]   fs_setting       = FULL_SCALE_RST;
    logic [INT_W-1:0]  interval_setting = DRIFT_INT_RST;
    t_stage            stage            = STAGE_CALIBRATE;
    int                cal_count        = 0;
    int                bias_y_sum       = 0;
    int                bias_z_sum       = 0;
    logic [TIME_W-1:0] last_us          = '0;
    logic [TIME_W-1:0] drift_mark_ms    = '0;
    logic [HEAD_W-1:0] head_h           = '0;
    logic [HEAD_W-1:0] head_v           = '0;
    logic [HEAD_W-1:0] drift_step_h     = '0;
    logic [HEAD_W-1:0] drift_step_v     = '0;
    logic [HEAD_W-1:0] snap_h           = '0;
    logic [HEAD_W-1:0] snap_v           = '0;

    // Stimulus-side timestamps and calibration sums, used to build samples that
    // hit exact corner cases such as a rate equal to the measured bias.
    logic [TIME_W-1:0] gen_us;
    logic [TIME_W-1:0] gen_ms;
    int                cal_y_sum = 0;
    int                cal_z_sum = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Headings live on a 360 degree circle in Q9.23.
    function automatic logic [HEAD_W-1:0] wrap_add(input logic [HEAD_W-1:0] a,
                                                   input logic [HEAD_W-1:0] b);
        return HEAD_W'((64'(a) + 64'(b)) % 64'(HEAD_MOD));
    endfunction

    // One integration step of one axis: the bias-corrected rate times the
    // elapsed microseconds, scaled to Q9.23 degrees and rounded half away from
    // zero. A positive corrected rate turns the heading backwards.
    function automatic logic [HEAD_W-1:0] step_heading(input logic [HEAD_W-1:0] head,
                                                       input int raw,
                                                       input int sum,
                                                       input logic [TIME_W-1:0] dt);
        longint       diff;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [127:0] div;
        logic [63:0]  qm;
        diff = longint'(raw) * CAL - longint'(sum);
        num  = 128'(diff < 0 ? -diff : diff);
        num  = num * fs_setting * (128'(1) << RND_SHIFT) * dt;
        div  = 128'(US_PER_S) * CAL;
        quo  = num / div;
        rem  = num % div;
        if (rem * 2 >= div) begin
            quo = quo + 1;
        end
        qm = 64'(quo % 128'(HEAD_MOD));
        if (diff > 0) begin
            return HEAD_W'((64'(head) + 64'(HEAD_MOD) - qm) % 64'(HEAD_MOD));
        end
        return wrap_add(head, HEAD_W'(qm));
    endfunction

    // Advances the predictor by one accepted sample and returns the headings
    // that the block must report for it.
    function automatic t_headings predict_headings(input t_sample s);
        int                ny;
        int                rz;
        logic [TIME_W-1:0] dt;
        t_headings         r;
        // The Y axis is mounted reversed; the one value that cannot be negated
        // saturates to the largest positive rate.
        ny = -int'($signed(s.rate_y));
        if (ny > 32767) begin
            ny = 32767;
        end
        rz = int'($signed(s.rate_z));
        if (stage == STAGE_CALIBRATE) begin
            if (cal_count == 0) begin
                last_us = s.t_us;
            end
            bias_y_sum += ny;
            bias_z_sum += rz;
            cal_count++;
            if (cal_count >= CAL) begin
                stage = STAGE_FIRST_UPDATE;
            end
        end else begin
            dt      = s.t_us - last_us;
            head_h  = step_heading(head_h, rz, bias_z_sum, dt);
            head_v  = step_heading(head_v, ny, bias_y_sum, dt);
            last_us = s.t_us;
            // Drift goes in only once strictly more than the interval passed.
            if (TIME_W'(s.t_ms - drift_mark_ms) > TIME_W'(interval_setting)) begin
                head_h        = wrap_add(head_h, drift_step_h);
                head_v        = wrap_add(head_v, drift_step_v);
                drift_mark_ms = s.t_ms;
            end
            if (stage == STAGE_FIRST_UPDATE) begin
                snap_h = head_h;
                snap_v = head_v;
                stage  = STAGE_SECOND_UPDATE;
            end else if (stage == STAGE_SECOND_UPDATE) begin
                drift_step_h  = wrap_add(head_h, HEAD_W'(HEAD_MOD - snap_h));
                drift_step_v  = wrap_add(head_v, HEAD_W'(HEAD_MOD - snap_v));
                drift_mark_ms = s.t_ms;
                stage         = STAGE_RUNNING;
            end
        end
        r.horiz = head_h;
        r.vert  = head_v;
        r.ready = (stage == STAGE_RUNNING);
        return r;
    endfunction

    // Input driver. A new sample is offered only when the channel is free or
    // its current transaction is being accepted, so a stalled payload holds.
    always @(posedge i_clk) begin : sample_driver
        t_sample accepted;
        t_sample next_item;
        logic    offer;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                accepted = '{rate_y: i_rate_y_raw, rate_z: i_rate_z_raw,
                             t_us: i_time_us, t_ms: i_time_ms};
                heading_queue.push_back(predict_headings(accepted));
                samples_sent++;
            end
            if (i_in_valid && o_in_stall) begin
                in_blocked_cycles++;
            end
            if (!i_in_valid || !o_in_stall) begin
                offer = (sample_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
                if (offer) begin
                    next_item    = sample_queue.pop_front();
                    i_rate_y_raw <= next_item.rate_y;
                    i_rate_z_raw <= next_item.rate_z;
                    i_time_us    <= next_item.t_us;
                    i_time_ms    <= next_item.t_ms;
                end
                i_in_valid <= offer;
            end
        end
    end

    // The long hold-off is timed here, independently of the stimulus process.
    always @(posedge i_clk) begin : hold_timer
        if (!pressure_on) begin
            hold_count <= 0;
        end else if (hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge i_clk) begin : result_stall
        i_out_stall <= (pressure_on && hold_count < HOLD_CYCLES)
                       || ($urandom_range(99) < stall_pct);
    end

    function automatic void compare_field(input string name,
                                          input logic [HEAD_W-1:0] want,
                                          input logic [HEAD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Output monitor: every accepted transaction must match the oldest entry.
    always @(posedge i_clk) begin : heading_monitor
        t_headings want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (heading_queue.size() == 0) begin
                $error("unexpected heading transaction: horizontal %0d vertical %0d",
                       o_horizontal_heading, o_vertical_heading);
                fail_count++;
            end else begin
                want = heading_queue.pop_front();
                compare_field("horizontal_heading", want.horiz, o_horizontal_heading);
                compare_field("vertical_heading", want.vert, o_vertical_heading);
                compare_field("ready_res", HEAD_W'(want.ready), HEAD_W'(o_ready_res));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, heading_queue.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // APB write: setup cycle, then an access cycle held until pready.
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FULL_SCALE) begin
            fs_setting = data[FS_W-1:0];
        end else begin
            interval_setting = data[INT_W-1:0];
        end
    endtask

    task automatic set_registers(input int full_scale, input int interval);
        write_register(ADDR_FULL_SCALE, APB_DATA_W'(full_scale));
        write_register(ADDR_DRIFT_INT, APB_DATA_W'(interval));
        settings_count++;
    endtask

    // Queues one sample whose timestamps move on by the given steps; both
    // counters wrap naturally at 32 bits.
    task automatic add_sample(input logic [RATE_W-1:0] y, input logic [RATE_W-1:0] z,
                              input logic [TIME_W-1:0] us_step,
                              input logic [TIME_W-1:0] ms_step);
        gen_us = gen_us + us_step;
        gen_ms = gen_ms + ms_step;
        sample_queue.push_back('{rate_y: y, rate_z: z, t_us: gen_us, t_ms: gen_ms});
        items_total++;
    endtask

    task automatic add_calibration_sample(input logic [RATE_W-1:0] y,
                                          input logic [RATE_W-1:0] z);
        int ny;
        ny = -int'($signed(y));
        if (ny > 32767) begin
            ny = 32767;
        end
        cal_y_sum += ny;
        cal_z_sum += int'($signed(z));
        add_sample(y, z, TIME_W'($urandom_range(20000)), TIME_W'($urandom_range(20)));
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(3))
            0: return RATE_W'($urandom);
            1: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return RATE_W'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Mostly a steady sample stream; now and then the timestamps jump by an
    // arbitrary amount, which also covers the wrap of both counters.
    task automatic add_random_sample();
        logic [TIME_W-1:0] us_step;
        logic [TIME_W-1:0] ms_step;
        if ($urandom_range(9) == 0) begin
            us_step = $urandom;
            ms_step = $urandom;
        end else begin
            us_step = TIME_W'($urandom_range(20000));
            if ($urandom_range(3) == 0) begin
                ms_step = '0;
            end else begin
                ms_step = TIME_W'($urandom_range(2 * int'(interval_setting) + 2));
            end
        end
        add_sample(pick_rate(), pick_rate(), us_step, ms_step);
    endtask

    // Waits until every queued sample went in and every result came back, then
    // leaves the block alone for longer than one update takes.
    task automatic drain_block();
        while (samples_sent != items_total || heading_queue.size() != 0) begin
            @(posedge i_clk);
        end
        send_idle_pct = 0;
        stall_pct     = 0;
        pressure_on   = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int gap_pct, input int hold_pct,
                              input bit pressure);
        send_idle_pct = gap_pct;
        stall_pct     = hold_pct;
        pressure_on   = pressure;
        for (int k = 0; k < count; k++) begin
            add_random_sample();
        end
        drain_block();
    endtask

    initial begin : stimulus
        int base;
        int ny;
        int nz;
        int zero_y;
        int zero_z;
        gen_us = $urandom;
        gen_ms = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Calibration under the reset configuration. The two saturating
        // extremes go first; the last sample is chosen so that both bias sums
        // are exact multiples of the sample count, which lets a later sample
        // sit exactly on the bias.
        add_calibration_sample(16'h8000, 16'h7FFF);
        add_calibration_sample(16'h7FFF, 16'h8000);
        for (int k = 2; k < CAL - 1; k++) begin
            add_calibration_sample(pick_rate(), pick_rate());
        end
        base = int'($urandom_range(20000)) - 10000;
        ny   = base - (((cal_y_sum + base) % CAL) + CAL) % CAL;
        base = int'($urandom_range(20000)) - 10000;
        nz   = base - (((cal_z_sum + base) % CAL) + CAL) % CAL;
        add_calibration_sample(RATE_W'(-ny), RATE_W'(nz));
        zero_y = -(cal_y_sum / CAL);
        zero_z = cal_z_sum / CAL;

        // The two updates that measure the drift.
        add_random_sample();
        add_random_sample();

        // Directed corner cases on the running integrator.
        add_sample(16'h8000, 16'h7FFF, 32'd10000, 32'd10);
        add_sample(16'h7FFF, 16'h8000, 32'd10000, 32'd200);
        // Exactly the interval since the last drift add: no drift this time.
        add_sample(16'h0000, 16'h0000, 32'd10000, 32'd100);
        // One millisecond more: now the drift goes in.
        add_sample(16'hFFFF, 16'h0001, 32'd10000, 32'd1);
        // A rate equal to the bias leaves the heading alone.
        add_sample(RATE_W'(zero_y), RATE_W'(zero_z), 32'd10000, 32'd100);
        // No time elapsed at all.
        add_sample(16'h5555, 16'hAAAA, 32'd0, 32'd0);
        // The largest elapsed time: both counters step back by one.
        add_sample(16'hAAAA, 16'h5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Park both counters just below the wrap, then step across it.
        add_sample(16'h1234, 16'hEDCB, 32'hFFFF_FFF0 - gen_us, 32'hFFFF_FFF0 - gen_ms);
        add_sample(16'h7FFF, 16'h7FFF, 32'h20, 32'h200);
        add_sample(16'h8000, 16'h8000, 32'd9000, 32'd9);
        drain_block();

        // Random phases across full-scale and interval settings, with every
        // idling pattern, including a long receiver hold-off.
        set_registers(2000, 1);
        run_random(350, 0, 0, 1'b0);
        set_registers(250, 65535);
        run_random(350, 50, 0, 1'b0);
        set_registers(2047, 0);
        run_random(350, 0, 50, 1'b0);
        set_registers(0, 500);
        run_random(200, 21, 21, 1'b0);
        set_registers(1, 1000);
        run_random(200, 0, 0, 1'b1);
        set_registers(1500, 50);
        run_random(350, 21, 21, 1'b0);

        $display("Sent %0d gyro samples and checked %0d heading results over %0d settings.",
                 samples_sent, results_checked, settings_count + 1);
        $display("The block held off the sample input for %0d cycles in total.",
                 in_blocked_cycles);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
